>>> hw/rtl/ips_pkg.sv
package ips_pkg;

  localparam int TIME_WIDTH = 64;
  localparam int COUNT_W    = 32;
  localparam int WLEN_W     = 32;
  localparam int LOAD_W     = 16;
  localparam int RATE_W     = 32;

  localparam int LS_W = 14;
  localparam int RS_W = 30;
  localparam logic [LS_W-1:0] LOAD_SCALE = LS_W'(10000);
  localparam logic [RS_W-1:0] RATE_SCALE = RS_W'(1000000000);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(5000000);

  localparam int PROD_LOAD_W = TIME_WIDTH + LS_W;
  localparam int PROD_RATE_W = COUNT_W + RS_W;
  localparam int PROD_W      = (PROD_LOAD_W > PROD_RATE_W) ? PROD_LOAD_W : PROD_RATE_W;

  localparam int BIT_CNT_W = $clog2(TIME_WIDTH);
  localparam int DIV_CNT_W = $clog2(RATE_W);

endpackage

>>> hw/rtl/interval_profiler_statistics.sv
// Interval profiler statistics. Each request carries the start and stop
// timestamps of one measured interval and yields one result with the period,
// running minimum, maximum, saturating total and count, and the load and rate
// of the last closed window. The datapath is bit-serial: an item walks through
// the period, accumulator, compare and elapsed-time logic one bit per cycle,
// so the block takes no new request until it is through with the last one. A
// request that closes a window adds two constant multiplies and a shared
// radix-2 restoring divider that runs 16 steps for load and 32 for rate; a
// quotient that saturates skips its divide steps. The result sits in an
// output register, so a stalled result does not hold up the next request's
// work.
module interval_profiler_statistics (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_wr_en,
  input  logic [ips_pkg::WLEN_W-1:0]        cfg_wr_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ips_pkg::TIME_WIDTH-1:0]    in_start_time,
  input  logic [ips_pkg::TIME_WIDTH-1:0]    in_stop_time,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ips_pkg::TIME_WIDTH-1:0]    out_period,
  output logic [ips_pkg::TIME_WIDTH-1:0]    out_min_period,
  output logic [ips_pkg::TIME_WIDTH-1:0]    out_max_period,
  output logic [ips_pkg::TIME_WIDTH-1:0]    out_total_time,
  output logic [ips_pkg::COUNT_W-1:0]       out_event_count,
  output logic [ips_pkg::LOAD_W-1:0]        out_load_centipercent,
  output logic [ips_pkg::RATE_W-1:0]        out_rate_milli_per_s,
  output logic                              out_window_closed
);

  localparam int TW  = ips_pkg::TIME_WIDTH;
  localparam int CW  = ips_pkg::COUNT_W;
  localparam int PW  = ips_pkg::PROD_W;
  localparam int LW  = ips_pkg::LOAD_W;
  localparam int RW  = ips_pkg::RATE_W;
  localparam int BCW = ips_pkg::BIT_CNT_W;
  localparam int DCW = ips_pkg::DIV_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_MUL,
    ST_SETUP,
    ST_STEP,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [ips_pkg::WLEN_W-1:0] wlen_r;

  logic [TW-1:0] min_r, max_r, total_r, ws_r, taw_r;
  logic [CW-1:0] count_r, caw_r;
  logic [LW-1:0] load_r;
  logic [RW-1:0] rate_r;

  logic [TW-1:0] start_sr, now_sr, wl_sr;
  logic [TW-1:0] period_r, elapsed_r, busy_r;
  logic [CW-1:0] events_r;
  logic [BCW-1:0] bit_cnt_r;
  logic pb_r, eb_r, tc_r, bb_r, lt_r, gtmax_r, gtwl_r;
  logic closed_r;

  logic [PW-1:0]  prod_r;
  logic [TW-1:0]  rem_r;
  logic [RW-1:0]  low_r;
  logic [RW-1:0]  q_r;
  logic [DCW-1:0] div_cnt_r;
  logic           div_rate_r;

  // bit-serial datapath
  logic n_b, s_b, w_b, t_b, a_b, mn_b, mx_b, l_b;
  logic p_bit, e_bit, sum_bit, busy_bit;
  logic pb_nxt, eb_nxt, tc_nxt, bb_nxt, lt_nxt, gtmax_nxt, gtwl_nxt;

  assign n_b  = now_sr[0];
  assign s_b  = start_sr[0];
  assign w_b  = ws_r[0];
  assign t_b  = total_r[0];
  assign a_b  = taw_r[0];
  assign mn_b = min_r[0];
  assign mx_b = max_r[0];
  assign l_b  = wl_sr[0];

  assign p_bit     = n_b ^ s_b ^ pb_r;
  assign pb_nxt    = (~n_b & s_b) | (~(n_b ^ s_b) & pb_r);
  assign e_bit     = n_b ^ w_b ^ eb_r;
  assign eb_nxt    = (~n_b & w_b) | (~(n_b ^ w_b) & eb_r);
  assign sum_bit   = p_bit ^ t_b ^ tc_r;
  assign tc_nxt    = (p_bit & t_b) | (p_bit & tc_r) | (t_b & tc_r);
  assign busy_bit  = sum_bit ^ a_b ^ bb_r;
  assign bb_nxt    = (~sum_bit & a_b) | (~(sum_bit ^ a_b) & bb_r);
  assign lt_nxt    = (~p_bit & mn_b) | (~(p_bit ^ mn_b) & lt_r);
  assign gtmax_nxt = (p_bit & ~mx_b) | (~(p_bit ^ mx_b) & gtmax_r);
  assign gtwl_nxt  = (e_bit & ~l_b) | (~(e_bit ^ l_b) & gtwl_r);

  // end-of-scan values
  logic [TW-1:0] total_new;
  logic [CW-1:0] count_new;
  logic          ws_unset;

  assign total_new = tc_r ? {TW{1'b1}} : total_r;
  assign count_new = (&count_r) ? count_r : count_r + CW'(1);
  assign ws_unset  = ~|ws_r;

  // constant multiplies
  logic [ips_pkg::PROD_LOAD_W-1:0] prod_load;
  logic [ips_pkg::PROD_RATE_W-1:0] prod_rate;

  assign prod_load = {{ips_pkg::LS_W{1'b0}}, busy_r}
                   * {{TW{1'b0}}, ips_pkg::LOAD_SCALE};
  assign prod_rate = {{ips_pkg::RS_W{1'b0}}, events_r}
                   * {{CW{1'b0}}, ips_pkg::RATE_SCALE};

  // divider
  logic [PW-1:0] hi_val;
  logic          div_sat;
  logic [TW:0]   trial, diff;
  logic          ge;
  logic [RW-1:0] q_nxt;

  assign hi_val  = div_rate_r ? PW'(prod_r >> RW) : PW'(prod_r >> LW);
  assign div_sat = hi_val >= PW'(elapsed_r);
  assign trial   = {rem_r, low_r[RW-1]};
  assign diff    = trial - {1'b0, elapsed_r};
  assign ge      = trial >= {1'b0, elapsed_r};
  assign q_nxt   = {q_r[RW-2:0], ge};

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wlen_r     <= ips_pkg::WLEN_RESET;
      min_r      <= {TW{1'b1}};
      max_r      <= '0;
      total_r    <= '0;
      count_r    <= '0;
      ws_r       <= '0;
      taw_r      <= '0;
      caw_r      <= '0;
      load_r     <= '0;
      rate_r     <= '0;
      out_valid  <= 1'b0;
      bit_cnt_r  <= '0;
      div_cnt_r  <= '0;
      div_rate_r <= 1'b0;
      closed_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wlen_r <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state_r != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            start_sr  <= in_start_time;
            now_sr    <= in_stop_time;
            wl_sr     <= TW'(wlen_r);
            bit_cnt_r <= '0;
            pb_r      <= 1'b0;
            eb_r      <= 1'b0;
            tc_r      <= 1'b0;
            bb_r      <= 1'b0;
            lt_r      <= 1'b0;
            gtmax_r   <= 1'b0;
            gtwl_r    <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // advance one bit, LSB first; rotate what must survive the pass
          start_sr  <= start_sr >> 1;
          wl_sr     <= wl_sr >> 1;
          now_sr    <= {n_b, now_sr[TW-1:1]};
          ws_r      <= {w_b, ws_r[TW-1:1]};
          taw_r     <= {a_b, taw_r[TW-1:1]};
          min_r     <= {mn_b, min_r[TW-1:1]};
          max_r     <= {mx_b, max_r[TW-1:1]};
          total_r   <= {sum_bit, total_r[TW-1:1]};
          period_r  <= {p_bit, period_r[TW-1:1]};
          elapsed_r <= {e_bit, elapsed_r[TW-1:1]};
          busy_r    <= {busy_bit, busy_r[TW-1:1]};
          pb_r      <= pb_nxt;
          eb_r      <= eb_nxt;
          tc_r      <= tc_nxt;
          bb_r      <= bb_nxt;
          lt_r      <= lt_nxt;
          gtmax_r   <= gtmax_nxt;
          gtwl_r    <= gtwl_nxt;
          bit_cnt_r <= bit_cnt_r + BCW'(1);
          if (bit_cnt_r == BCW'(TW - 1)) begin
            state_r <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (lt_r) begin
            min_r <= period_r;
          end
          if (gtmax_r) begin
            max_r <= period_r;
          end
          total_r  <= total_new;
          count_r  <= count_new;
          closed_r <= 1'b0;
          state_r  <= ST_FINISH;
          if (ws_unset) begin
            ws_r  <= now_sr;
            taw_r <= total_new;
            caw_r <= count_new;
          end else if (gtwl_r) begin
            busy_r     <= tc_r ? ~taw_r : busy_r;
            events_r   <= count_new - caw_r;
            ws_r       <= now_sr;
            taw_r      <= total_new;
            caw_r      <= count_new;
            closed_r   <= 1'b1;
            div_rate_r <= 1'b0;
            state_r    <= ST_MUL;
          end
        end

        ST_MUL: begin
          prod_r  <= div_rate_r ? PW'(prod_rate) : PW'(prod_load);
          state_r <= ST_SETUP;
        end

        ST_SETUP: begin
          if (div_sat) begin
            if (div_rate_r) begin
              rate_r  <= {RW{1'b1}};
              state_r <= ST_FINISH;
            end else begin
              load_r     <= {LW{1'b1}};
              div_rate_r <= 1'b1;
              state_r    <= ST_MUL;
            end
          end else begin
            rem_r     <= hi_val[TW-1:0];
            low_r     <= div_rate_r ? prod_r[RW-1:0]
                                    : {prod_r[LW-1:0], {(RW - LW){1'b0}}};
            q_r       <= '0;
            div_cnt_r <= div_rate_r ? DCW'(RW - 1) : DCW'(LW - 1);
            state_r   <= ST_STEP;
          end
        end

        ST_STEP: begin
          rem_r     <= ge ? diff[TW-1:0] : trial[TW-1:0];
          low_r     <= low_r << 1;
          q_r       <= q_nxt;
          div_cnt_r <= div_cnt_r - DCW'(1);
          if (div_cnt_r == '0) begin
            if (div_rate_r) begin
              rate_r  <= q_nxt;
              state_r <= ST_FINISH;
            end else begin
              load_r     <= q_nxt[LW-1:0];
              div_rate_r <= 1'b1;
              state_r    <= ST_MUL;
            end
          end
        end

        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_period            <= period_r;
            out_min_period        <= min_r;
            out_max_period        <= max_r;
            out_total_time        <= total_r;
            out_event_count       <= count_r;
            out_load_centipercent <= load_r;
            out_rate_milli_per_s  <= rate_r;
            out_window_closed     <= closed_r;
            state_r               <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted request did not start the scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside finish");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r != '0) |-> (min_r <= max_r))
    else $error("minimum period exceeds maximum period");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (rem_r < elapsed_r))
    else $error("divider remainder not below divisor");

endmodule
